>>> rtl/ows_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ows_pkg
// types and constants shared by the one-wire temperature master
// ----------------------------------------------------------------------------
package ows_pkg;

    localparam int unsigned CFG_COUNT = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned TICK_W    = 12;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_CONVERT = 2'd1,
        CMD_READ    = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_W_LOW    = 4'd4,
        PH_W_DATA   = 4'd5,
        PH_W_REC    = 4'd6,
        PH_R_LOW    = 4'd7,
        PH_R_WAIT   = 4'd8,
        PH_R_TAIL   = 4'd9,
        PH_R_REC    = 4'd10
    } t_phase;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_TAIL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_DATA    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd7;

    // bus command bytes
    localparam logic [7:0] ROM_SKIP      = 8'hCC;
    localparam logic [7:0] FN_CONVERT    = 8'h44;
    localparam logic [7:0] FN_READ_PAD   = 8'hBE;

    localparam logic [1:0] BYTE_FIRST    = 2'd0;
    localparam logic [1:0] BYTE_SECOND   = 2'd1;
    localparam logic [1:0] BYTE_RX_LOW   = 2'd2;
    localparam logic [1:0] BYTE_RX_HIGH  = 2'd3;
    localparam logic [2:0] BIT_LAST      = 3'd7;

    typedef logic [CFG_W-1:0] t_cfg [CFG_COUNT];

    function automatic logic [CFG_W-1:0] cfg_default(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_W-1:0] v;
        unique case (idx)
            REG_RESET_LOW:     v = 12'd500;
            REG_PRESENCE_WAIT: v = 12'd75;
            REG_PRESENCE_TAIL: v = 12'd500;
            REG_WRITE_LOW:     v = 12'd10;
            REG_WRITE_DATA:    v = 12'd50;
            REG_READ_LOW:      v = 12'd5;
            REG_READ_SAMPLE:   v = 12'd5;
            REG_READ_TAIL:     v = 12'd50;
            default:           v = 12'd1;
        endcase
        return v;
    endfunction

    typedef struct packed {
        t_phase            phase;
        logic [TICK_W-1:0] tick_count;
        logic [2:0]        bit_index;
        logic [1:0]        byte_index;
        logic [7:0]        shift_byte;
        logic              is_read_job;
        logic [7:0]        low_byte_hold;
        logic [15:0]       temperature;
        logic              presence;
    } t_state;

    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        logic        no_presence;
        logic [15:0] temperature;
    } t_result;

endpackage

>>> rtl/ows_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ows_cfg
// slot timing register file, written through a plain write port
// ----------------------------------------------------------------------------
module ows_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ows_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ows_pkg::CFG_W-1:0]     i_cfg_data,
    output ows_pkg::t_cfg                 o_cfg
);
    import ows_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CFG_COUNT; i++) begin
            if (!i_rst_n) begin
                r_cfg[i] <= cfg_default(CFG_IDX_W'(i));
            end else if (i_cfg_we && (i_cfg_idx == CFG_IDX_W'(i))) begin
                r_cfg[i] <= i_cfg_data;
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/ows_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ows_step
// next state and per-tick result of the bus sequencer
// ----------------------------------------------------------------------------
module ows_step #(
    parameter int unsigned RECOVERY_TICKS = 2
) (
    input  ows_pkg::t_state  i_state,
    input  ows_pkg::t_cfg    i_cfg,
    input  logic [1:0]       i_command,
    input  logic             i_bus_in,
    output ows_pkg::t_state  o_state,
    output ows_pkg::t_result o_result
);
    import ows_pkg::*;

    localparam logic [TICK_W-1:0] REC_LEN = TICK_W'(RECOVERY_TICKS);

    t_state            s;
    t_phase            next_ph;
    logic              drive;
    logic              done;
    logic [TICK_W-1:0] raw_len;
    logic [TICK_W-1:0] len;
    logic [TICK_W:0]   tick_inc;

    always_comb begin
        s       = i_state;
        drive   = 1'b0;
        done    = 1'b0;
        raw_len = REC_LEN;

        // command start, same tick
        if (s.phase == PH_IDLE &&
            (t_cmd'(i_command) == CMD_CONVERT || t_cmd'(i_command) == CMD_READ)) begin
            s.phase       = PH_RST_LOW;
            s.tick_count  = '0;
            s.is_read_job = (t_cmd'(i_command) == CMD_READ);
            s.bit_index   = '0;
            s.byte_index  = BYTE_FIRST;
            s.shift_byte  = '0;
        end

        next_ph = s.phase;

        unique case (s.phase)
            PH_RST_LOW, PH_W_LOW, PH_R_LOW: drive = 1'b1;
            PH_W_DATA:                      drive = ~s.shift_byte[0];
            default:                        drive = 1'b0;
        endcase

        // samples on the first tick of the tail phases
        if (s.tick_count == '0) begin
            if (s.phase == PH_RST_TAIL) begin
                s.presence = i_bus_in;
            end else if (s.phase == PH_R_TAIL) begin
                s.shift_byte = {i_bus_in, s.shift_byte[7:1]};
            end
        end

        unique case (s.phase)
            PH_RST_LOW:  raw_len = i_cfg[REG_RESET_LOW];
            PH_RST_WAIT: raw_len = i_cfg[REG_PRESENCE_WAIT];
            PH_RST_TAIL: raw_len = i_cfg[REG_PRESENCE_TAIL];
            PH_W_LOW:    raw_len = i_cfg[REG_WRITE_LOW];
            PH_W_DATA:   raw_len = i_cfg[REG_WRITE_DATA];
            PH_R_LOW:    raw_len = i_cfg[REG_READ_LOW];
            PH_R_WAIT:   raw_len = i_cfg[REG_READ_SAMPLE];
            PH_R_TAIL:   raw_len = i_cfg[REG_READ_TAIL];
            default:     raw_len = REC_LEN;
        endcase
        len      = (raw_len == '0) ? TICK_W'(1) : raw_len;
        tick_inc = {1'b0, s.tick_count} + (TICK_W+1)'(1);

        if (s.phase != PH_IDLE) begin
            if (tick_inc >= {1'b0, len}) begin
                s.tick_count = '0;
                unique case (s.phase)
                    PH_RST_LOW:  next_ph = PH_RST_WAIT;
                    PH_RST_WAIT: next_ph = PH_RST_TAIL;
                    PH_RST_TAIL: begin
                        s.shift_byte = ROM_SKIP;
                        s.bit_index  = '0;
                        s.byte_index = BYTE_FIRST;
                        next_ph      = PH_W_LOW;
                    end
                    PH_W_LOW:    next_ph = PH_W_DATA;
                    PH_W_DATA:   next_ph = PH_W_REC;
                    PH_W_REC: begin
                        s.shift_byte = {1'b0, s.shift_byte[7:1]};
                        next_ph      = PH_W_LOW;
                        if (s.bit_index == BIT_LAST) begin
                            s.bit_index = '0;
                            if (s.byte_index == BYTE_FIRST) begin
                                s.byte_index = BYTE_SECOND;
                                s.shift_byte = s.is_read_job ? FN_READ_PAD : FN_CONVERT;
                            end else if (s.is_read_job) begin
                                s.byte_index = BYTE_RX_LOW;
                                s.shift_byte = '0;
                                next_ph      = PH_R_LOW;
                            end else begin
                                next_ph = PH_IDLE;
                                done    = 1'b1;
                            end
                        end else begin
                            s.bit_index = s.bit_index + 3'd1;
                        end
                    end
                    PH_R_LOW:    next_ph = PH_R_WAIT;
                    PH_R_WAIT:   next_ph = PH_R_TAIL;
                    PH_R_TAIL:   next_ph = PH_R_REC;
                    PH_R_REC: begin
                        next_ph = PH_R_LOW;
                        if (s.bit_index == BIT_LAST) begin
                            s.bit_index = '0;
                            if (s.byte_index == BYTE_RX_LOW) begin
                                s.low_byte_hold = s.shift_byte;
                                s.byte_index    = BYTE_RX_HIGH;
                                s.shift_byte    = '0;
                            end else begin
                                s.temperature = {s.shift_byte, s.low_byte_hold};
                                next_ph       = PH_IDLE;
                                done          = 1'b1;
                            end
                        end else begin
                            s.bit_index = s.bit_index + 3'd1;
                        end
                    end
                    default:     next_ph = PH_IDLE;
                endcase
                s.phase = next_ph;
            end else begin
                s.tick_count = tick_inc[TICK_W-1:0];
            end
        end

        o_state                = s;
        o_result.drive_low     = drive;
        o_result.busy          = (s.phase != PH_IDLE);
        o_result.done          = done;
        o_result.no_presence   = s.presence;
        o_result.temperature   = s.temperature;
    end

endmodule

>>> rtl/onewire_temp_sensor_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_temp_sensor_master
// one-wire bus master for convert and read-temperature transactions
// ----------------------------------------------------------------------------
// usage
//   one input transfer is one microsecond tick: a command (0 none, 1 start
//   conversion, 2 read temperature) and the sampled bus level for the tick
//   every input transfer yields exactly one result transfer: the open-drain
//   pull-low drive for that tick, busy, a one-tick done pulse, the presence
//   sample and the last read temperature (signed, 1/16 degree)
//   commands are taken only while idle; slot timing comes from eight
//   12-bit tick-count registers on the write port, written while idle
// registers and throughput
//   the sequencer state and the result register both update at the input
//   transfer, from the same combinational step; one tick per cycle while the
//   receiver is not stalling the result channel
// reset and stall
//   synchronous active-low reset returns the sequencer to idle, clears the
//   result register and loads the default slot timings
//   a stalled receiver holds the result; a new tick is still taken in the
//   cycle the held result is taken, so there is no bubble
// ----------------------------------------------------------------------------
module onewire_temp_sensor_master #(
    parameter int unsigned RECOVERY_TICKS = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [ows_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ows_pkg::CFG_W-1:0]     i_cfg_data,
    // tick input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic                          i_bus_in,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_drive_low,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic                          o_no_presence,
    output logic signed [15:0]            o_temperature
);
    import ows_pkg::*;

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    in_xfer;

    ows_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ows_step #(
        .RECOVERY_TICKS (RECOVERY_TICKS)
    ) u_step (
        .i_state   (r_state),
        .i_cfg     (cfg),
        .i_command (i_command),
        .i_bus_in  (i_bus_in),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // take a tick whenever the result slot is empty or being emptied
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_result    <= '0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
            r_result    <= n_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_low   = r_result.drive_low;
    assign o_busy_res    = r_result.busy;
    assign o_done_res    = r_result.done;
    assign o_no_presence = r_result.no_presence;
    assign o_temperature = $signed(r_result.temperature);

endmodule
